// ----- rtl/emft_pkg.sv -----
// ----------------------------------------------------------------------------
// emft_pkg: shared types and constants of the forwarding table
// Table geometry, command and status codes, and the item structs.
// ----------------------------------------------------------------------------
package emft_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENTRY_COUNT_W = 5;
  localparam int unsigned CNT_EXT_W = (CNT_W > ENTRY_COUNT_W) ? CNT_W : ENTRY_COUNT_W;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned NODE_W = 8;

  localparam logic CMD_MAP    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Register index of default_node, as decoded from paddr[2].
  localparam logic REG_DEFAULT_NODE = 1'b0;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] address;
    logic [NODE_W-1:0] node_id;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]        result_node;
    logic                     hit;
    logic                     status;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic              re;
    logic [IDX_W-1:0]  raddr;
    logic              addr_we;
    logic              node_we;
    logic [IDX_W-1:0]  waddr;
    logic [ADDR_W-1:0] addr_wdata;
    logic [NODE_W-1:0] node_wdata;
  } ram_req_t;

  // The entry count is reported in its low bits only.
  function automatic logic [ENTRY_COUNT_W-1:0] count_field(logic [CNT_W-1:0] c);
    logic [CNT_EXT_W-1:0] w;
    w = CNT_EXT_W'(c);
    return w[ENTRY_COUNT_W-1:0];
  endfunction

endpackage

// ----- rtl/emft_ram.sv -----
// ----------------------------------------------------------------------------
// emft_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module emft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/emft_ctrl.sv -----
// ----------------------------------------------------------------------------
// emft_ctrl: search sequencer and shared address comparator
// Walks entries in order via one comparator; a map updates a non-full table.
// ----------------------------------------------------------------------------
module emft_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  emft_pkg::in_item_t        in_item_i,
  output logic                      busy_o,
  output logic                      done_o,
  output emft_pkg::out_item_t       result_o,
  input  logic [emft_pkg::NODE_W-1:0] default_node_i,
  output emft_pkg::ram_req_t        ram_req_o,
  input  logic [emft_pkg::ADDR_W-1:0] addr_rdata_i,
  input  logic [emft_pkg::NODE_W-1:0] node_rdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic                          cmd_q, cmd_d;
  logic [emft_pkg::ADDR_W-1:0]   addr_q, addr_d;
  logic [emft_pkg::NODE_W-1:0]   node_q, node_d;
  logic [emft_pkg::NODE_W-1:0]   found_node_q, found_node_d;
  logic                          hit_q, hit_d;
  logic                          full_q, full_d;
  logic [emft_pkg::IDX_W-1:0]    match_idx_q, match_idx_d;
  logic [emft_pkg::CNT_W-1:0]    idx_q, idx_d;
  logic                          cmp_vld_q, cmp_vld_d;
  logic [emft_pkg::IDX_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic [emft_pkg::CNT_W-1:0]    count_q, count_d;
  emft_pkg::out_item_t           res_q, res_d;
  logic                          done_q, done_d;
  logic                          addr_eq;

  // The single comparator, fed by the registered read of the address store.
  assign addr_eq = (addr_rdata_i == addr_q);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    addr_d       = addr_q;
    node_d       = node_q;
    found_node_d = found_node_q;
    hit_d        = hit_q;
    full_d       = full_q;
    match_idx_d  = match_idx_q;
    idx_d        = idx_q;
    cmp_vld_d    = cmp_vld_q;
    cmp_idx_d    = cmp_idx_q;
    count_d      = count_q;
    res_d        = res_q;
    done_d       = 1'b0;

    ram_req_o            = '0;
    ram_req_o.raddr      = idx_q[emft_pkg::IDX_W-1:0];
    ram_req_o.addr_wdata = addr_q;
    ram_req_o.node_wdata = node_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_d     = in_item_i.command;
          addr_d    = in_item_i.address;
          node_d    = in_item_i.node_id;
          idx_d     = '0;
          cmp_vld_d = 1'b0;
          hit_d     = 1'b0;
          full_d    = (in_item_i.command == emft_pkg::CMD_MAP) &&
                      (count_q >= emft_pkg::CNT_W'(emft_pkg::TABLE_DEPTH));
          state_d   = full_d ? ST_FINISH : ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        // Reads are issued one entry ahead of the compare.
        cmp_vld_d = 1'b0;
        if (idx_q < count_q) begin
          ram_req_o.re = 1'b1;
          idx_d        = idx_q + emft_pkg::CNT_W'(1);
          cmp_vld_d    = 1'b1;
          cmp_idx_d    = idx_q[emft_pkg::IDX_W-1:0];
        end
        if (cmp_vld_q && addr_eq) begin
          hit_d        = 1'b1;
          match_idx_d  = cmp_idx_q;
          found_node_d = node_rdata_i;
          cmp_vld_d    = 1'b0;
          state_d      = ST_FINISH;
        end else if (idx_q == count_q) begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        done_d             = 1'b1;
        state_d            = ST_IDLE;
        res_d.result_node  = '0;
        res_d.hit          = 1'b0;
        res_d.status       = full_q ? emft_pkg::STATUS_FULL : emft_pkg::STATUS_OK;
        if (cmd_q == emft_pkg::CMD_MAP) begin
          if (!full_q) begin
            if (hit_q) begin
              ram_req_o.node_we = 1'b1;
              ram_req_o.waddr   = match_idx_q;
              res_d.hit         = 1'b1;
            end else begin
              ram_req_o.addr_we = 1'b1;
              ram_req_o.node_we = 1'b1;
              ram_req_o.waddr   = count_q[emft_pkg::IDX_W-1:0];
              count_d           = count_q + emft_pkg::CNT_W'(1);
            end
          end
        end else begin
          res_d.result_node = hit_q ? found_node_q : default_node_i;
          res_d.hit         = hit_q;
        end
        res_d.entry_count = emft_pkg::count_field(count_d);
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    addr_q       <= addr_d;
    node_q       <= node_d;
    found_node_q <= found_node_d;
    hit_q        <= hit_d;
    full_q       <= full_d;
    match_idx_q  <= match_idx_d;
    idx_q        <= idx_d;
    cmp_idx_q    <= cmp_idx_d;
    res_q        <= res_d;
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  a_finish_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH |=> done_q && state_q == ST_IDLE)
    else $error("finish cycle not followed by a result");

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= emft_pkg::CNT_W'(emft_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_no_growth_on_hit_or_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (res_q.hit || res_q.status == emft_pkg::STATUS_FULL) |-> $stable(count_q))
    else $error("entry count changed on an update, lookup hit or refusal");

  a_search_within_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.re |-> state_q == ST_SEARCH && idx_q < count_q)
    else $error("entry read outside the filled part of the table");
`endif

endmodule

// ----- rtl/exact_match_forwarding_table.sv -----
// ----------------------------------------------------------------------------
// exact_match_forwarding_table: address to next-node table with default route
// Start an item with start_i while busy_o is low. A map item stores or updates
// an address, a lookup item returns the stored node or the default node.
// Each item gives one result on result_o, marked by done_o for one cycle; the
// receiver has no way to stall it. A new item may start in that same cycle,
// but no earlier: the table works on one item at a time.
// An item walks the filled entries from entry 0 through the address store,
// one read and one compare per cycle through the single comparator, and stops
// at the first match; a map into a full table skips the walk.
// default_node is written over the APB port at byte address 0; the user must write
// it only while idle, which the block itself does not enforce. pready_o is always high.
// Reset empties the table (entry count 0) and clears default_node to 0; the
// stores themselves are not cleared, as only filled entries are ever read.
// ----------------------------------------------------------------------------
module exact_match_forwarding_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  emft_pkg::in_item_t  in_item_i,
  output logic                busy_o,
  output logic                done_o,
  output emft_pkg::out_item_t result_o,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [2:0]          paddr_i,
  input  logic [31:0]         pwdata_i,
  output logic [31:0]         prdata_o,
  output logic                pready_o
);

  logic [emft_pkg::NODE_W-1:0] default_node_q;
  logic [emft_pkg::ADDR_W-1:0] addr_rdata;
  logic [emft_pkg::NODE_W-1:0] node_rdata;
  emft_pkg::ram_req_t          ram_req;
  logic                        cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_node_q <= '0;
    end else if (cfg_wr && paddr_i[2] == emft_pkg::REG_DEFAULT_NODE) begin
      default_node_q <= pwdata_i[emft_pkg::NODE_W-1:0];
    end
  end

  assign prdata_o = (paddr_i[2] == emft_pkg::REG_DEFAULT_NODE) ?
                    32'(default_node_q) : '0;

  emft_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .in_item_i      (in_item_i),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .result_o       (result_o),
    .default_node_i (default_node_q),
    .ram_req_o      (ram_req),
    .addr_rdata_i   (addr_rdata),
    .node_rdata_i   (node_rdata)
  );

  emft_ram #(
    .WIDTH (emft_pkg::ADDR_W),
    .DEPTH (emft_pkg::TABLE_DEPTH)
  ) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.addr_we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.addr_wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (addr_rdata)
  );

  emft_ram #(
    .WIDTH (emft_pkg::NODE_W),
    .DEPTH (emft_pkg::TABLE_DEPTH)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.node_we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.node_wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (node_rdata)
  );

endmodule

// ----- tb/sv/exact_match_forwarding_table_tb.sv -----
// ----------------------------------------------------------------------------
// exact_match_forwarding_table_tb: self-checking bench for the forwarding table
// A directed list of map and lookup items (empty table, extreme addresses and
// node ids, node 0, updates and misses) is followed by random phases in which
// the table fills up and maps are refused. An in-bench table model predicts
// every result that the directed list does not pin, and the default node is rewritten and read back between phases.
// ----------------------------------------------------------------------------
module exact_match_forwarding_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] DEFAULT_NODE_ADDR = {emft_pkg::REG_DEFAULT_NODE, 2'b00};
  localparam logic [2:0] UNUSED_REG_ADDR   = {~emft_pkg::REG_DEFAULT_NODE, 2'b00};
  localparam int unsigned PHASE_ITEMS = 170;

  typedef struct {
    emft_pkg::in_item_t  stim;
    bit                  pinned;
    emft_pkg::out_item_t result;
  } route_case_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  emft_pkg::in_item_t  in_item_i;
  logic                busy_o;
  logic                done_o;
  emft_pkg::out_item_t result_o;
  logic                psel_i;
  logic                penable_i;
  logic                pwrite_i;
  logic [2:0]          paddr_i;
  logic [31:0]         pwdata_i;
  logic [31:0]         prdata_o;
  logic                pready_o;

  // Model of the table as seen from outside.
  logic [emft_pkg::ADDR_W-1:0] held_addr [emft_pkg::TABLE_DEPTH];
  logic [emft_pkg::NODE_W-1:0] held_node [emft_pkg::TABLE_DEPTH];
  int unsigned                 held_count;
  logic [emft_pkg::NODE_W-1:0] default_route;

  emft_pkg::out_item_t awaited_results[$];
  route_case_t         directed[$];
  bit                  pin_valid;
  emft_pkg::out_item_t pin_result;
  int unsigned         sender_idle_pct;
  int unsigned         mismatch_count;

  exact_match_forwarding_table uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .in_item_i (in_item_i),
    .busy_o    (busy_o),
    .done_o    (done_o),
    .result_o  (result_o),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic emft_pkg::out_item_t route_item(input emft_pkg::in_item_t it);
    emft_pkg::out_item_t r;
    int                  found;
    r = '0;
    r.status = emft_pkg::STATUS_OK;
    found = -1;
    for (int i = 0; i < held_count; i++) begin
      if (found < 0 && held_addr[i] == it.address) found = i;
    end
    if (it.command == emft_pkg::CMD_MAP) begin
      // A full table refuses every map, even one that would only update.
      if (held_count >= emft_pkg::TABLE_DEPTH) begin
        r.status = emft_pkg::STATUS_FULL;
      end else if (found >= 0) begin
        held_node[found] = it.node_id;
        r.hit = 1'b1;
      end else begin
        held_addr[held_count] = it.address;
        held_node[held_count] = it.node_id;
        held_count++;
      end
    end else if (found >= 0) begin
      r.result_node = held_node[found];
      r.hit = 1'b1;
    end else begin
      r.result_node = default_route;
    end
    r.entry_count = emft_pkg::ENTRY_COUNT_W'(held_count);
    return r;
  endfunction

  function automatic void write_register(input logic [2:0] addr, input logic [31:0] data);
    if (addr[2] == emft_pkg::REG_DEFAULT_NODE) default_route = data[emft_pkg::NODE_W-1:0];
  endfunction

  // Mostly addresses already held, so that updates, hits and near misses dominate.
  function automatic emft_pkg::in_item_t draw_route_item();
    emft_pkg::in_item_t          it;
    logic [emft_pkg::ADDR_W-1:0] known;
    it.command = $urandom_range(1) ? emft_pkg::CMD_LOOKUP : emft_pkg::CMD_MAP;
    it.node_id = emft_pkg::NODE_W'($urandom_range(255));
    it.address = $urandom;
    if (held_count > 0) begin
      known = held_addr[$urandom_range(held_count - 1)];
      if (it.command == emft_pkg::CMD_MAP) begin
        if ($urandom_range(5) != 0) it.address = known;
      end else begin
        case ($urandom_range(3))
          0: ;
          1: it.address = known ^ (32'h1 << $urandom_range(31));
          default: it.address = known;
        endcase
      end
    end
    return it;
  endfunction

  function automatic route_case_t route_case(input logic cmd, input logic [31:0] addr,
      input logic [7:0] nid, input bit pinned, input logic [7:0] rnode,
      input logic hit, input logic st, input logic [4:0] cnt);
    route_case_t c;
    c.stim.command = cmd;
    c.stim.address = addr;
    c.stim.node_id = nid;
    c.pinned = pinned;
    c.result.result_node = rnode;
    c.result.hit = hit;
    c.result.status = st;
    c.result.entry_count = cnt;
    return c;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
      input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  // Results are taken at the rising edge; a new item may be accepted at the same edge.
  always @(posedge clk_i) begin : result_monitor
    emft_pkg::out_item_t want;
    if (rst_ni === 1'b1) begin
      if (done_o === 1'b1) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none awaited, got %0h", $realtime, result_o);
        end else begin
          want = awaited_results.pop_front();
          check_field("result_node", 32'(want.result_node), 32'(result_o.result_node));
          check_field("hit", 32'(want.hit), 32'(result_o.hit));
          check_field("status", 32'(want.status), 32'(result_o.status));
          check_field("entry_count", 32'(want.entry_count), 32'(result_o.entry_count));
        end
      end
      if (start_i && !busy_o) begin
        want = route_item(in_item_i);
        if (pin_valid) want = pin_result;
        awaited_results.push_back(want);
      end
    end
  end

  // Called at a falling edge; returns at the rising edge that accepts the item.
  task automatic issue(input emft_pkg::in_item_t item, input bit pinned,
      input emft_pkg::out_item_t result);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      in_item_i <= draw_route_item();
      @(negedge clk_i);
    end
    pin_valid = pinned;
    pin_result = result;
    start_i <= 1'b1;
    in_item_i <= item;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr,
      input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel_i <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i <= wr;
    paddr_i <= addr;
    pwdata_i <= wdata;
    @(negedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (pready_o !== 1'b1);
    rdata = prdata_o;
    @(negedge clk_i);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
  endtask

  // Sets the default node, pokes the unused register slot and reads the value back.
  task automatic configure(input logic [7:0] node);
    logic [31:0] wdata;
    logic [31:0] rdata;
    wdata = {24'($urandom), node};
    apb_access(1'b1, DEFAULT_NODE_ADDR, wdata, rdata);
    write_register(DEFAULT_NODE_ADDR, wdata);
    apb_access(1'b1, UNUSED_REG_ADDR, ~wdata, rdata);
    write_register(UNUSED_REG_ADDR, ~wdata);
    apb_access(1'b0, DEFAULT_NODE_ADDR, '0, rdata);
    check_field("default_node readback", 32'(default_route), rdata);
  endtask

  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned idle_pct, input logic [7:0] node);
    settle();
    configure(node);
    sender_idle_pct = idle_pct;
    repeat (PHASE_ITEMS) begin
      @(negedge clk_i);
      issue(draw_route_item(), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    rst_ni = 1'b0;
    start_i = 1'b0;
    in_item_i = '0;
    psel_i = 1'b0;
    penable_i = 1'b0;
    pwrite_i = 1'b0;
    paddr_i = '0;
    pwdata_i = '0;
    pin_valid = 1'b0;
    pin_result = '0;
    sender_idle_pct = 0;
    mismatch_count = 0;
    held_count = 0;
    default_route = '0;

    // Empty table, extreme addresses and node ids, node 0 stored and found,
    // updates that keep the count, and misses one bit away from a held address.
    directed.push_back(route_case(emft_pkg::CMD_LOOKUP, 32'h0000_0000, 8'h00, 1'b1,
                                  8'hFF, 1'b0, emft_pkg::STATUS_OK, 5'd0));
    directed.push_back(route_case(emft_pkg::CMD_MAP,    32'h0000_0000, 8'h00, 1'b1,
                                  8'h00, 1'b0, emft_pkg::STATUS_OK, 5'd1));
    directed.push_back(route_case(emft_pkg::CMD_LOOKUP, 32'h0000_0000, 8'hFF, 1'b1,
                                  8'h00, 1'b1, emft_pkg::STATUS_OK, 5'd1));
    directed.push_back(route_case(emft_pkg::CMD_MAP,    32'hFFFF_FFFF, 8'hFF, 1'b1,
                                  8'h00, 1'b0, emft_pkg::STATUS_OK, 5'd2));
    directed.push_back(route_case(emft_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 8'h00, 1'b1,
                                  8'hFF, 1'b1, emft_pkg::STATUS_OK, 5'd2));
    directed.push_back(route_case(emft_pkg::CMD_MAP,    32'hFFFF_FFFF, 8'h5A, 1'b1,
                                  8'h00, 1'b1, emft_pkg::STATUS_OK, 5'd2));
    directed.push_back(route_case(emft_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 8'h00, 1'b1,
                                  8'h5A, 1'b1, emft_pkg::STATUS_OK, 5'd2));
    directed.push_back(route_case(emft_pkg::CMD_LOOKUP, 32'h8000_0000, 8'h00, 1'b1,
                                  8'hFF, 1'b0, emft_pkg::STATUS_OK, 5'd2));
    directed.push_back(route_case(emft_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 8'hA5, 1'b1,
                                  8'hFF, 1'b0, emft_pkg::STATUS_OK, 5'd2));
    directed.push_back(route_case(emft_pkg::CMD_MAP,    32'h8000_0000, 8'h01, 1'b0,
                                  '0, 1'b0, emft_pkg::STATUS_OK, '0));
    directed.push_back(route_case(emft_pkg::CMD_MAP,    32'h0000_0001, 8'h80, 1'b0,
                                  '0, 1'b0, emft_pkg::STATUS_OK, '0));
    directed.push_back(route_case(emft_pkg::CMD_MAP,    32'h8000_0000, 8'hA5, 1'b0,
                                  '0, 1'b0, emft_pkg::STATUS_OK, '0));
    directed.push_back(route_case(emft_pkg::CMD_LOOKUP, 32'h8000_0000, 8'h00, 1'b0,
                                  '0, 1'b0, emft_pkg::STATUS_OK, '0));
    directed.push_back(route_case(emft_pkg::CMD_LOOKUP, 32'h0000_0001, 8'h00, 1'b0,
                                  '0, 1'b0, emft_pkg::STATUS_OK, '0));
    directed.push_back(route_case(emft_pkg::CMD_MAP,    32'h0000_0000, 8'hC3, 1'b0,
                                  '0, 1'b0, emft_pkg::STATUS_OK, '0));
    directed.push_back(route_case(emft_pkg::CMD_LOOKUP, 32'h0000_0000, 8'h00, 1'b0,
                                  '0, 1'b0, emft_pkg::STATUS_OK, '0));
    directed.push_back(route_case(emft_pkg::CMD_LOOKUP, 32'hFFFF_FFFE, 8'h00, 1'b0,
                                  '0, 1'b0, emft_pkg::STATUS_OK, '0));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    configure(8'hFF);
    foreach (directed[i]) begin
      @(negedge clk_i);
      issue(directed[i].stim, directed[i].pinned, directed[i].result);
    end

    // The table fills during these phases, after which every map is refused.
    random_phase(0, 8'h00);
    random_phase(81, 8'($urandom_range(255)));
    random_phase(8, 8'hFF);

    settle();
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #3ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
